### rtl/tli_pkg.sv
`timescale 1ns / 1ps

package tli_pkg;

   localparam int DEF_TABLE_DEPTH = 64;
   localparam int Q_W             = 32;
   localparam int CNT_W           = 7;
   localparam int IDX_W           = 6;
   localparam int SEG_W           = 6;
   localparam int STAT_W          = 2;
   localparam int MAG_W           = 32;
   localparam int NUM_W           = 48;
   localparam int PROD_W          = MAG_W + NUM_W;
   localparam int STEP_W          = 6;
   localparam int ARITH_STEPS     = NUM_W;
   localparam int CSR_AW          = 3;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FEW_PTS = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_ZERO_DX = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_POINT_COUNT = 3'd0;

   localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic                    opcode;
      logic [IDX_W-1:0]        point_index;
      logic signed [Q_W-1:0]   point_x;
      logic signed [Q_W-1:0]   point_y;
      logic signed [Q_W-1:0]   query_x;
      logic                    last_query;
   } req_type;

   typedef struct packed {
      logic signed [Q_W-1:0]   interp_y;
      logic [SEG_W-1:0]        segment;
      logic [STAT_W-1:0]       status;
      logic                    last_flag;
   } rsp_type;

   typedef struct packed {
      logic                    start;
      logic [NUM_W-1:0]        num;
      logic [MAG_W-1:0]        den;
      logic [MAG_W-1:0]        mcand;
   } arith_cmd_type;

   typedef struct packed {
      logic                    done;
      logic [PROD_W-1:0]       product;
   } arith_res_type;

   typedef enum logic [1:0] {
      AP_IDLE,
      AP_DIV,
      AP_MUL,
      AP_DONE
   } arith_phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_ENDS,
      ST_SRCH,
      ST_SCMP,
      ST_PT_LO,
      ST_PT_HI,
      ST_PREP,
      ST_WAIT,
      ST_OUT
   } tli_state_type;

endpackage

### rtl/tli_arith.sv
`timescale 1ns / 1ps

// Bit-serial restoring divide followed by bit-serial shift-add multiply:
// product = (num / den) * mcand, one quotient bit and one multiplier bit a cycle.
module tli_arith
   import tli_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  arith_cmd_type cmd,
   output arith_res_type res
);

   arith_phase_type    phase_ff, phase_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [MAG_W-1:0]   rem_ff, rem_in;
   logic [MAG_W-1:0]   den_ff;
   logic [MAG_W-1:0]   mcand_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [MAG_W:0]     shifted;
   logic [MAG_W:0]     trial;
   logic               ge;
   logic [MAG_W:0]     acc;
   logic               last_step;

   assign last_step = (step_ff == '0);

   // divide step
   always_comb begin
      shifted = {rem_ff, num_ff[NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      ge      = (shifted >= {1'b0, den_ff});
   end

   // multiply step
   always_comb begin
      acc = {1'b0, prod_ff[PROD_W-1:NUM_W]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
   end

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         AP_IDLE: if (cmd.start) phase_in = AP_DIV;
         AP_DIV:  if (last_step) phase_in = AP_MUL;
         AP_MUL:  if (last_step) phase_in = AP_DONE;
         AP_DONE: phase_in = AP_IDLE;
         default: phase_in = AP_IDLE;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      prod_in = prod_ff;
      case (phase_ff)
         AP_IDLE: begin
            if (cmd.start) begin
               num_in  = cmd.num;
               rem_in  = '0;
               step_in = STEP_W'(ARITH_STEPS - 1);
            end
         end
         AP_DIV: begin
            num_in  = {num_ff[NUM_W-2:0], ge};
            rem_in  = ge ? trial[MAG_W-1:0] : shifted[MAG_W-1:0];
            step_in = step_ff - 1'b1;
            if (last_step) begin
               prod_in = {{MAG_W{1'b0}}, num_ff[NUM_W-2:0], ge};
               step_in = STEP_W'(ARITH_STEPS - 1);
            end
         end
         AP_MUL: begin
            prod_in = {acc, prod_ff[NUM_W-1:1]};
            step_in = step_ff - 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      res.done    = (phase_ff == AP_DONE);
      res.product = prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= AP_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      prod_ff <= prod_in;
      if (phase_ff == AP_IDLE && cmd.start) begin
         den_ff   <= cmd.den;
         mcand_ff <= cmd.mcand;
      end
   end

endmodule

### rtl/table_linear_interpolator.sv
`timescale 1ns / 1ps
// Load beats: one per cycle while no query is in flight, written at the accepting edge, no response.
// Query with fewer than two points: response valid in the cycle after acceptance.
// Other queries: a clamped end skips the binary search, else the search runs (at most
// floor(log2(n)) + 1 probes); then the 48-step serial divide and 48-step serial multiply run;
// a zero-width segment skips both and answers straight after the segment setup.
// One query in flight; next beat taken the cycle after the response beat. Synchronous reset.
module table_linear_interpolator
   import tli_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)(
   input  logic                clock,
   input  logic                reset,
   // request beats
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   // response beats
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   // register port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // breakpoint store, one read port with registered data
   logic signed [Q_W-1:0] x_mem [TABLE_DEPTH];
   logic signed [Q_W-1:0] y_mem [TABLE_DEPTH];
   logic signed [Q_W-1:0] x_rd_ff;
   logic signed [Q_W-1:0] y_rd_ff;
   logic [AW-1:0]         rd_addr;
   logic                  load_we;

   tli_state_type         state_ff, state_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CW-1:0]         n_ff, n_in;
   logic signed [Q_W-1:0] q_ff;
   logic                  last_ff;
   logic signed [Q_W-1:0] x0_ff;
   logic                  asc_ff, asc_in;
   logic [CW-1:0]         lo_ff, hi_ff;
   logic [AW-1:0]         mid_ff;
   logic [AW-1:0]         j_ff;
   logic signed [Q_W-1:0] xj_ff, yj_ff;
   logic                  oneg_ff;
   rsp_type               rsp_ff;

   logic                  csr_we;
   logic                  query_go;
   logic                  few_pts;
   logic                  clamp_lo, clamp_hi;
   logic [CW:0]           mid_sum;
   logic [CW-1:0]         mid_w;
   logic [CW-1:0]         lo_m1, j_lim;
   logic                  go_right;
   logic signed [Q_W:0]   dx, dq, dy;
   logic [Q_W:0]          dx_abs, dq_abs, dy_abs;
   logic                  oneg_in;
   logic signed [Q_W+16:0] y_sum;
   logic signed [Q_W-1:0] y_fin;
   arith_cmd_type         acmd;
   arith_res_type         ares;

   // -------------------------------------------------------------------
   // register port: one register, point_count, at byte address zero
   // -------------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_we = psel && penable && pwrite && pready && (paddr == CSR_POINT_COUNT);
   assign prdata = (paddr == CSR_POINT_COUNT) ? {{(32-CNT_W){1'b0}}, count_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_we) begin
         count_ff <= pwdata[CNT_W-1:0];
      end
   end

   // -------------------------------------------------------------------
   // datapath helpers
   // -------------------------------------------------------------------
   always_comb begin
      // clamp the count to the table depth
      if (32'(count_ff) > TABLE_DEPTH) n_in = CW'(TABLE_DEPTH);
      else                             n_in = CW'(count_ff);
      few_pts  = (n_in < CW'(2));
      query_go = req_valid && req_ready && (req_data.opcode == OP_QUERY);
      load_we  = req_valid && req_ready && (req_data.opcode == OP_LOAD) &&
                 (32'(req_data.point_index) < TABLE_DEPTH);

      // ends of the table: x0_ff holds x[0], x_rd_ff holds x[n-1]
      asc_in   = (x_rd_ff >= x0_ff);
      clamp_lo = asc_in ? (x0_ff >= q_ff) : (x0_ff <= q_ff);
      clamp_hi = asc_in ? (x_rd_ff <= q_ff) : (x_rd_ff >= q_ff);

      // binary search
      mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
      mid_w    = mid_sum[CW:1];
      go_right = ((q_ff >= x_rd_ff) == asc_ff);
      lo_m1    = (lo_ff == '0) ? '0 : lo_ff - 1'b1;
      j_lim    = (lo_m1 > n_ff - CW'(2)) ? n_ff - CW'(2) : lo_m1;

      // segment differences: x_rd_ff, y_rd_ff hold point j+1
      dx = {x_rd_ff[Q_W-1], x_rd_ff} - {xj_ff[Q_W-1], xj_ff};
      dq = {q_ff[Q_W-1], q_ff} - {xj_ff[Q_W-1], xj_ff};
      dy = {y_rd_ff[Q_W-1], y_rd_ff} - {yj_ff[Q_W-1], yj_ff};
      dx_abs  = dx[Q_W] ? (Q_W+1)'(0) - dx : dx;
      dq_abs  = dq[Q_W] ? (Q_W+1)'(0) - dq : dq;
      dy_abs  = dy[Q_W] ? (Q_W+1)'(0) - dy : dy;
      oneg_in = (dq[Q_W] != dx[Q_W]) != dy[Q_W];

      // final offset: saturate on product overflow, else add and clamp
      y_sum = oneg_ff ?
              {{17{yj_ff[Q_W-1]}}, yj_ff} - {2'b00, ares.product[62:16]} :
              {{17{yj_ff[Q_W-1]}}, yj_ff} + {2'b00, ares.product[62:16]};
      if (|ares.product[PROD_W-1:63]) y_fin = oneg_ff ? Q_MIN : Q_MAX;
      else if (y_sum > $signed({{17{1'b0}}, Q_MAX}))  y_fin = Q_MAX;
      else if (y_sum < $signed({{17{1'b1}}, Q_MIN}))  y_fin = Q_MIN;
      else                                            y_fin = y_sum[Q_W-1:0];
   end

   // -------------------------------------------------------------------
   // sequencer: next state
   // -------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_go) state_in = few_pts ? ST_OUT : ST_FIRST;
         end
         ST_FIRST: state_in = ST_LAST;
         ST_LAST:  state_in = ST_ENDS;
         ST_ENDS:  state_in = (clamp_lo || clamp_hi) ? ST_PT_LO : ST_SRCH;
         ST_SRCH:  state_in = (lo_ff < hi_ff) ? ST_SCMP : ST_PT_LO;
         ST_SCMP:  state_in = ST_SRCH;
         ST_PT_LO: state_in = ST_PT_HI;
         ST_PT_HI: state_in = ST_PREP;
         ST_PREP:  state_in = (dx == '0) ? ST_OUT : ST_WAIT;
         ST_WAIT:  if (ares.done) state_in = ST_OUT;
         ST_OUT:   if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // -------------------------------------------------------------------
   // sequencer: outputs
   // -------------------------------------------------------------------
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      rsp_valid  = (state_ff == ST_OUT);
      rd_addr    = '0;
      acmd.start = 1'b0;
      acmd.num   = {dq_abs[MAG_W-1:0], 16'h0000};
      acmd.den   = dx_abs[MAG_W-1:0];
      acmd.mcand = dy_abs[MAG_W-1:0];
      case (state_ff)
         ST_FIRST: rd_addr = '0;
         ST_LAST:  rd_addr = AW'(n_ff - CW'(1));
         ST_SRCH:  rd_addr = AW'(mid_w);
         ST_PT_LO: rd_addr = j_ff;
         ST_PT_HI: rd_addr = AW'(j_ff + 1'b1);
         ST_PREP:  acmd.start = (dx != '0);
         default:  ;
      endcase
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // table write and registered read
   always_ff @(posedge clock) begin
      if (load_we) begin
         x_mem[AW'(req_data.point_index)] <= req_data.point_x;
         y_mem[AW'(req_data.point_index)] <= req_data.point_y;
      end
      x_rd_ff <= x_mem[rd_addr];
      y_rd_ff <= y_mem[rd_addr];
   end

   // working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               q_ff    <= req_data.query_x;
               last_ff <= req_data.last_query;
               n_ff    <= n_in;
               rsp_ff  <= '{interp_y: '0, segment: '0, status: STATUS_FEW_PTS,
                            last_flag: req_data.last_query};
            end
         end
         ST_LAST: x0_ff <= x_rd_ff;
         ST_ENDS: begin
            asc_ff <= asc_in;
            lo_ff  <= '0;
            hi_ff  <= n_ff;
            if (clamp_lo)      j_ff <= '0;
            else if (clamp_hi) j_ff <= AW'(n_ff - CW'(2));
         end
         ST_SRCH: begin
            mid_ff <= AW'(mid_w);
            if (!(lo_ff < hi_ff)) j_ff <= AW'(j_lim);
         end
         ST_SCMP: begin
            if (go_right) lo_ff <= CW'(mid_ff) + 1'b1;
            else          hi_ff <= CW'(mid_ff);
         end
         ST_PT_HI: begin
            xj_ff <= x_rd_ff;
            yj_ff <= y_rd_ff;
         end
         ST_PREP: begin
            oneg_ff <= oneg_in;
            // zero-width segment: hold the lower ordinate
            rsp_ff  <= '{interp_y: yj_ff, segment: SEG_W'(j_ff), status: STATUS_ZERO_DX,
                         last_flag: last_ff};
         end
         ST_WAIT: begin
            if (ares.done) begin
               rsp_ff <= '{interp_y: y_fin, segment: SEG_W'(j_ff), status: STATUS_OK,
                           last_flag: last_ff};
            end
         end
         default: ;
      endcase
   end

   tli_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (acmd),
      .res   (ares)
   );

   // -------------------------------------------------------------------
   // checks
   // -------------------------------------------------------------------
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      query_go |=> !req_ready)
      else $error("block took a query while idle afterwards");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.opcode == OP_LOAD) |=> !rsp_valid)
      else $error("load beat produced a response");

   a_few_pts_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_FEW_PTS) |->
      (rsp_data.interp_y == '0 && rsp_data.segment == '0))
      else $error("short-table response not zero");

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_FEW_PTS) |->
      (32'(j_ff) + 2 <= 32'(n_ff)))
      else $error("segment beyond last pair of points");

   a_arith_done: assert property (@(posedge clock) disable iff (reset)
      ares.done |-> state_ff == ST_WAIT)
      else $error("arithmetic finished outside wait");

endmodule
